FILE: hdl/qdr_pkg.sv
// Shared types, constants and the step classifier of the quadrature decoder.
package qdr_pkg;

   localparam int COUNT_BITS = 16;
   localparam int HALF_W     = COUNT_BITS - 1;

   localparam int CFG_W      = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam int DIR_W      = 2;
   localparam int HALF_OUT_W = 15;
   localparam int RPM_W      = 16;
   localparam int MODE_W     = 2;

   localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd2;

   localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
   localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_BACK = 2'd2;

   localparam logic [CFG_W-1:0] COUNT_MODULUS_RST = 16'd32768;
   localparam logic [CFG_W-1:0] SAMPLE_PERIOD_RST = 16'd10;
   localparam logic [CFG_W-1:0] PULSES_RST        = 16'd1;
   localparam logic [CFG_W-1:0] MAX_RPM_RST       = 16'd65535;

   localparam int SCALE_MS  = 1000;
   localparam int SCALE_MIN = 60;

   // diff < 2^16, times 1000 stays below 2^26
   localparam int DIFF_W = 16;
   localparam int PPS_W  = 26;

   localparam int DIV_N_W    = 32;
   localparam int DIV_D_W    = 17;
   localparam int DIV_STEP_W = $clog2(DIV_N_W);

   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   typedef enum logic [1:0] {
      REG_COUNT_MODULUS = 2'd0,
      REG_SAMPLE_PERIOD = 2'd1,
      REG_PULSES        = 2'd2,
      REG_MAX_RPM       = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      OP_FWD  = 3'd0,
      OP_BACK = 3'd1,
      OP_STOP = 3'd2,
      OP_TICK = 3'd3,
      OP_LOAD = 3'd4,
      OP_NOP  = 3'd5
   } op_type;

   typedef struct packed {
      logic [CFG_W-1:0] count_modulus;
      logic [CFG_W-1:0] sample_period_ms;
      logic [CFG_W-1:0] pulses_per_rev;
      logic [CFG_W-1:0] max_rpm;
   } cfg_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_N_W-1:0] quotient;
      logic [DIV_D_W-1:0] remainder;
   } div_rsp_type;

   // Gray-code step from previous {A,B} to current {A,B}
   function automatic op_type classify(logic [1:0] prev, logic [1:0] cur);
      logic [3:0] code;
      op_type     op;
      code = {prev, cur};
      case (code)
         4'h1, 4'h7, 4'hE, 4'h8: op = OP_FWD;
         4'h2, 4'hB, 4'hD, 4'h4: op = OP_BACK;
         default:                op = OP_STOP;
      endcase
      return op;
   endfunction

endpackage

FILE: hdl/quadrature_decoder_rpm.sv
// Top level of the quadrature decoder with speed measurement.
//
//   channel   direction   handshake               payload
//   req_      in          push / full             mode, phase_a, phase_b
//   rsp_      out         pop / empty             direction, half_count, speed_rpm
//   csr_      in/out      APB, pready tied high   four 16-bit registers at 4*i
//
// A sample, load or unused-mode item goes through the command queue into the result register.
// A tick holds the back end for three 32-step divisions (modulo, /sample_period_ms,
// /pulses_per_rev) on one shared serial divider.
// A two-entry command queue lets the input side keep taking items during a tick or while
// a result waits to be popped; req_full rises once the queue is full.
// Synchronous active-high reset clears counts, direction and speed and restores the registers.
module quadrature_decoder_rpm (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [qdr_pkg::MODE_W-1:0]          req_mode,
   input  logic                                req_phase_a,
   input  logic                                req_phase_b,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [qdr_pkg::DIR_W-1:0]           rsp_direction,
   output logic [qdr_pkg::HALF_OUT_W-1:0]      rsp_half_count,
   output logic [qdr_pkg::RPM_W-1:0]           rsp_speed_rpm,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [qdr_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [qdr_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [qdr_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   qdr_pkg::cfg_type          cfg_ff, cfg_in;
   qdr_pkg::reg_index_type    reg_index;
   logic                      csr_write;
   logic [qdr_pkg::CFG_W-1:0] wdata;
   logic [qdr_pkg::CFG_W-1:0] rdata;

   logic                      cmd_push, cmd_full, cmd_take, cmd_empty;
   qdr_pkg::op_type           cmd_push_op, cmd_pop_op;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = qdr_pkg::reg_index_type'(csr_paddr[qdr_pkg::CSR_ADDR_W-1:2]);
   assign wdata      = csr_pwdata[qdr_pkg::CFG_W-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_index)
            qdr_pkg::REG_COUNT_MODULUS: cfg_in.count_modulus    = wdata;
            qdr_pkg::REG_SAMPLE_PERIOD: cfg_in.sample_period_ms = wdata;
            qdr_pkg::REG_PULSES:        cfg_in.pulses_per_rev   = wdata;
            qdr_pkg::REG_MAX_RPM:       cfg_in.max_rpm          = wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         qdr_pkg::REG_COUNT_MODULUS: rdata = cfg_ff.count_modulus;
         qdr_pkg::REG_SAMPLE_PERIOD: rdata = cfg_ff.sample_period_ms;
         qdr_pkg::REG_PULSES:        rdata = cfg_ff.pulses_per_rev;
         qdr_pkg::REG_MAX_RPM:       rdata = cfg_ff.max_rpm;
         default:                    rdata = '0;
      endcase
   end

   assign csr_prdata = qdr_pkg::CSR_DATA_W'(rdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.count_modulus    <= qdr_pkg::COUNT_MODULUS_RST;
         cfg_ff.sample_period_ms <= qdr_pkg::SAMPLE_PERIOD_RST;
         cfg_ff.pulses_per_rev   <= qdr_pkg::PULSES_RST;
         cfg_ff.max_rpm          <= qdr_pkg::MAX_RPM_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   qdr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_mode    (req_mode),
      .req_phase_a (req_phase_a),
      .req_phase_b (req_phase_b),
      .req_full    (req_full),
      .cmd_full    (cmd_full),
      .cmd_push    (cmd_push),
      .cmd_op      (cmd_push_op)
   );

   qdr_cmd_fifo u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .push_op (cmd_push_op),
      .full    (cmd_full),
      .pop     (cmd_take),
      .pop_op  (cmd_pop_op),
      .empty   (cmd_empty)
   );

   qdr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .cmd_valid      (!cmd_empty),
      .cmd_op         (cmd_pop_op),
      .cmd_take       (cmd_take),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_direction  (rsp_direction),
      .rsp_half_count (rsp_half_count),
      .rsp_speed_rpm  (rsp_speed_rpm)
   );

endmodule

FILE: hdl/qdr_front.sv
// Front end: accepts input items, tracks the phase levels and classifies each item.
module qdr_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   input  logic [qdr_pkg::MODE_W-1:0]  req_mode,
   input  logic                        req_phase_a,
   input  logic                        req_phase_b,
   output logic                        req_full,
   input  logic                        cmd_full,
   output logic                        cmd_push,
   output qdr_pkg::op_type             cmd_op
);

   logic [1:0] prev_phase_ff, prev_phase_in;
   logic [1:0] cur_phase;

   assign cur_phase = {req_phase_a, req_phase_b};
   assign req_full  = cmd_full;
   assign cmd_push  = req_push && !cmd_full;

   always_comb begin
      prev_phase_in = prev_phase_ff;
      case (req_mode)
         qdr_pkg::MODE_SAMPLE: begin
            cmd_op        = qdr_pkg::classify(prev_phase_ff, cur_phase);
            prev_phase_in = cur_phase;
         end
         qdr_pkg::MODE_TICK: begin
            cmd_op = qdr_pkg::OP_TICK;
         end
         qdr_pkg::MODE_LOAD: begin
            cmd_op        = qdr_pkg::OP_LOAD;
            prev_phase_in = cur_phase;
         end
         default: begin
            cmd_op = qdr_pkg::OP_NOP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_phase_ff <= 2'b00;
      end else if (cmd_push) begin
         prev_phase_ff <= prev_phase_in;
      end
   end

endmodule

FILE: hdl/qdr_cmd_fifo.sv
// Short command queue between the front end and the back end.
module qdr_cmd_fifo (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  qdr_pkg::op_type push_op,
   output logic            full,
   input  logic            pop,
   output qdr_pkg::op_type pop_op,
   output logic            empty
);

   qdr_pkg::op_type                 entry_ff [qdr_pkg::CMD_DEPTH];
   logic [qdr_pkg::CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [qdr_pkg::CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [qdr_pkg::CMD_CNT_W-1:0]   count_ff, count_in;
   logic                            do_push, do_pop;

   assign full    = (count_ff == qdr_pkg::CMD_CNT_W'(qdr_pkg::CMD_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_op  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == qdr_pkg::CMD_PTR_W'(qdr_pkg::CMD_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == qdr_pkg::CMD_PTR_W'(qdr_pkg::CMD_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

FILE: hdl/qdr_div.sv
// Restoring serial divider, one quotient bit per cycle.
module qdr_div (
   input  logic                 clock,
   input  logic                 reset,
   input  qdr_pkg::div_req_type req,
   output qdr_pkg::div_rsp_type rsp
);

   localparam int NW = qdr_pkg::DIV_N_W;
   localparam int DW = qdr_pkg::DIV_D_W;

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [qdr_pkg::DIV_STEP_W-1:0]     step_ff, step_in;
   logic [DW-1:0]                      rem_ff, rem_in;
   logic [NW-1:0]                      quo_ff, quo_in;
   logic [DW-1:0]                      dvs_ff, dvs_in;
   logic [DW:0]                        shifted;
   logic [DW+1:0]                      trial;
   logic                               fits;

   assign shifted = {rem_ff, quo_ff[NW-1]};
   assign trial   = {1'b0, shifted} - {2'b00, dvs_ff};
   assign fits    = !trial[DW+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? trial[DW-1:0] : shifted[DW-1:0];
         quo_in  = {quo_ff[NW-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == qdr_pkg::DIV_STEP_W'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

FILE: hdl/qdr_back.sv
// Back end: counter, direction and speed computation, and the result register.
module qdr_back (
   input  logic                              clock,
   input  logic                              reset,
   input  qdr_pkg::cfg_type                  cfg,
   input  logic                              cmd_valid,
   input  qdr_pkg::op_type                   cmd_op,
   output logic                              cmd_take,
   input  logic                              rsp_pop,
   output logic                              rsp_empty,
   output logic [qdr_pkg::DIR_W-1:0]         rsp_direction,
   output logic [qdr_pkg::HALF_OUT_W-1:0]    rsp_half_count,
   output logic [qdr_pkg::RPM_W-1:0]         rsp_speed_rpm
);

   localparam int CB = qdr_pkg::COUNT_BITS;
   localparam int HW = qdr_pkg::HALF_W;
   localparam int NW = qdr_pkg::DIV_N_W;
   localparam int DW = qdr_pkg::DIV_D_W;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MOD  = 6'b000010,
      ST_MUL1 = 6'b000100,
      ST_DIV1 = 6'b001000,
      ST_MUL2 = 6'b010000,
      ST_DIV2 = 6'b100000
   } state_type;

   state_type                         state_ff, state_in;
   logic [CB-1:0]                     edge_count_ff, edge_count_in;
   logic [HW-1:0]                     last_half_ff, last_half_in;
   logic [qdr_pkg::DIR_W-1:0]         dir_ff, dir_in;
   logic [qdr_pkg::RPM_W-1:0]         rpm_ff, rpm_in;
   logic                              neg_ff, neg_in;
   logic [qdr_pkg::DIFF_W-1:0]        diff_ff, diff_in;
   logic [qdr_pkg::PPS_W-1:0]         pps_ff, pps_in;

   logic                              out_valid_ff, out_valid_in;
   logic [qdr_pkg::DIR_W-1:0]         out_dir_ff;
   logic [qdr_pkg::HALF_OUT_W-1:0]    out_half_ff, out_half_in;
   logic [qdr_pkg::RPM_W-1:0]         out_rpm_ff;
   logic                              out_wr;

   logic [HW-1:0]                     half;
   logic [HW:0]                       delta;
   logic                              delta_neg;
   logic [HW-1:0]                     delta_mag;
   logic [DW-1:0]                     modulus;
   logic [qdr_pkg::PPS_W-1:0]         scaled_ms;
   logic [NW-1:0]                     scaled_min;
   logic [NW-1:0]                     half_ext;
   logic [qdr_pkg::RPM_W-1:0]         rpm_sel;
   logic                              no_rate;

   qdr_pkg::div_req_type              div_req;
   qdr_pkg::div_rsp_type              div_rsp;

   qdr_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign half      = edge_count_ff[CB-1:1];
   assign delta     = {1'b0, half} - {1'b0, last_half_ff};
   assign delta_neg = delta[HW];
   assign delta_mag = delta_neg ? (~delta[HW-1:0] + 1'b1) : delta[HW-1:0];
   // a zero modulus means the full 16-bit range
   assign modulus   = (cfg.count_modulus == '0) ? DW'(32'h10000) : {1'b0, cfg.count_modulus};
   assign scaled_ms  = qdr_pkg::PPS_W'(diff_ff) * qdr_pkg::PPS_W'(qdr_pkg::SCALE_MS);
   assign scaled_min = NW'(pps_ff) * NW'(qdr_pkg::SCALE_MIN);
   assign no_rate    = (cfg.sample_period_ms == '0) || (cfg.pulses_per_rev == '0);

   assign cmd_take = (state_ff == ST_IDLE) && cmd_valid && (!out_valid_ff || rsp_pop);

   always_comb begin
      if (no_rate || (div_rsp.quotient > NW'(cfg.max_rpm))) begin
         rpm_sel = cfg.max_rpm;
      end else begin
         rpm_sel = div_rsp.quotient[qdr_pkg::RPM_W-1:0];
      end
   end

   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      case (state_ff)
         ST_IDLE: begin
            div_req.start    = cmd_take && (cmd_op == qdr_pkg::OP_TICK);
            div_req.dividend = NW'(delta_mag);
            div_req.divisor  = modulus;
         end
         ST_MUL1: begin
            div_req.start    = 1'b1;
            div_req.dividend = NW'(scaled_ms);
            div_req.divisor  = {1'b0, cfg.sample_period_ms};
         end
         ST_MUL2: begin
            div_req.start    = 1'b1;
            div_req.dividend = scaled_min;
            div_req.divisor  = {1'b0, cfg.pulses_per_rev};
         end
         default: begin
            div_req.start = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      edge_count_in = edge_count_ff;
      last_half_in  = last_half_ff;
      dir_in        = dir_ff;
      rpm_in        = rpm_ff;
      neg_in        = neg_ff;
      diff_in       = diff_ff;
      pps_in        = pps_ff;
      out_wr        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_take) begin
               out_wr = (cmd_op != qdr_pkg::OP_TICK);
               case (cmd_op)
                  qdr_pkg::OP_FWD: begin
                     edge_count_in = edge_count_ff + 1'b1;
                     dir_in        = qdr_pkg::DIR_FWD;
                  end
                  qdr_pkg::OP_BACK: begin
                     edge_count_in = edge_count_ff - 1'b1;
                     dir_in        = qdr_pkg::DIR_BACK;
                  end
                  qdr_pkg::OP_STOP: begin
                     dir_in = qdr_pkg::DIR_STOP;
                  end
                  qdr_pkg::OP_LOAD: begin
                     edge_count_in = '0;
                     last_half_in  = '0;
                     dir_in        = qdr_pkg::DIR_STOP;
                     rpm_in        = '0;
                  end
                  qdr_pkg::OP_TICK: begin
                     neg_in   = delta_neg;
                     state_in = ST_MOD;
                  end
                  default: begin
                     out_wr = 1'b1;
                  end
               endcase
            end
         end
         ST_MOD: begin
            if (div_rsp.done) begin
               // true modulo: fold a negative remainder back into range
               if (neg_ff && (div_rsp.remainder != '0)) begin
                  diff_in = qdr_pkg::DIFF_W'(modulus - div_rsp.remainder);
               end else begin
                  diff_in = div_rsp.remainder[qdr_pkg::DIFF_W-1:0];
               end
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            state_in = ST_DIV1;
         end
         ST_DIV1: begin
            if (div_rsp.done) begin
               pps_in   = div_rsp.quotient[qdr_pkg::PPS_W-1:0];
               state_in = ST_MUL2;
            end
         end
         ST_MUL2: begin
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            if (div_rsp.done) begin
               rpm_in       = rpm_sel;
               last_half_in = half;
               out_wr       = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign half_ext     = NW'(edge_count_in[CB-1:1]);
   assign out_half_in  = half_ext[qdr_pkg::HALF_OUT_W-1:0];
   assign out_valid_in = out_wr || (out_valid_ff && !rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         edge_count_ff <= '0;
         last_half_ff  <= '0;
         dir_ff        <= qdr_pkg::DIR_STOP;
         rpm_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         edge_count_ff <= edge_count_in;
         last_half_ff  <= last_half_in;
         dir_ff        <= dir_in;
         rpm_ff        <= rpm_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      diff_ff <= diff_in;
      pps_ff  <= pps_in;
      if (out_wr) begin
         out_dir_ff  <= dir_in;
         out_half_ff <= out_half_in;
         out_rpm_ff  <= rpm_in;
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_direction  = out_dir_ff;
   assign rsp_half_count = out_half_ff;
   assign rsp_speed_rpm  = out_rpm_ff;

   // divider results only come back while a tick is waiting on them
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_MOD || state_ff == ST_DIV1 || state_ff == ST_DIV2))
      else $error("divider finished outside a wait state");

   // the result slot was freed when the tick was taken and nothing else fills it
   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV2 && div_rsp.done) |-> !out_valid_ff)
      else $error("tick result would overwrite a pending result");

   // the edge counter moves by one step at most, or is cleared by a load
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (edge_count_ff == $past(edge_count_ff) ||
                edge_count_ff == CB'($past(edge_count_ff) + 1'b1) ||
                edge_count_ff == CB'($past(edge_count_ff) - 1'b1) ||
                edge_count_ff == '0))
      else $error("edge counter jumped");

endmodule

FILE: dv/qdr_decode_checker.sv
// Checker for the quadrature decoder: watches all channels, predicts each result and compares.
`timescale 1ns / 1ps

module qdr_decode_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   input  logic                           req_full,
   input  logic [qdr_pkg::MODE_W-1:0]     req_mode,
   input  logic                           req_phase_a,
   input  logic                           req_phase_b,
   input  logic                           rsp_empty,
   input  logic                           rsp_pop,
   input  logic [qdr_pkg::DIR_W-1:0]      rsp_direction,
   input  logic [qdr_pkg::HALF_OUT_W-1:0] rsp_half_count,
   input  logic [qdr_pkg::RPM_W-1:0]      rsp_speed_rpm,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [qdr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [qdr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic [qdr_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  logic                           csr_pready,
   output int                             mismatch_count,
   output int                             outstanding
);

   typedef struct packed {
      logic [qdr_pkg::DIR_W-1:0]      direction;
      logic [qdr_pkg::HALF_OUT_W-1:0] half_count;
      logic [qdr_pkg::RPM_W-1:0]      speed_rpm;
   } enc_status_type;

   enc_status_type                   expected_status[$];

   qdr_pkg::cfg_type                 cfg;
   logic [1:0]                       prev_ab;
   logic [qdr_pkg::COUNT_BITS-1:0]   edge_cnt;
   logic [qdr_pkg::HALF_W-1:0]       last_half;
   logic [qdr_pkg::DIR_W-1:0]        dir_q;
   logic [qdr_pkg::RPM_W-1:0]        rpm_q;

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   // next {A,B} level for one forward step
   function automatic logic [1:0] gray_fwd(logic [1:0] ab);
      case (ab)
         2'b00:   return 2'b01;
         2'b01:   return 2'b11;
         2'b11:   return 2'b10;
         default: return 2'b00;
      endcase
   endfunction

   function automatic logic [qdr_pkg::RPM_W-1:0] tick_speed(logic [qdr_pkg::HALF_W-1:0] half);
      longint modulus;
      longint delta;
      longint rate;
      modulus = (cfg.count_modulus == '0) ? 64'd65536 : longint'(cfg.count_modulus);
      delta   = (longint'(half) - longint'(last_half)) % modulus;
      if (delta < 0)
         delta += modulus;
      if (cfg.sample_period_ms == '0 || cfg.pulses_per_rev == '0) begin
         rate = longint'(cfg.max_rpm);
      end else begin
         rate = (delta * qdr_pkg::SCALE_MS) / longint'(cfg.sample_period_ms);
         rate = (rate * qdr_pkg::SCALE_MIN) / longint'(cfg.pulses_per_rev);
      end
      if (rate > longint'(cfg.max_rpm))
         rate = longint'(cfg.max_rpm);
      return rate[qdr_pkg::RPM_W-1:0];
   endfunction

   function automatic logic [qdr_pkg::CFG_W-1:0] reg_value(qdr_pkg::reg_index_type idx);
      case (idx)
         qdr_pkg::REG_COUNT_MODULUS: return cfg.count_modulus;
         qdr_pkg::REG_SAMPLE_PERIOD: return cfg.sample_period_ms;
         qdr_pkg::REG_PULSES:        return cfg.pulses_per_rev;
         default:                    return cfg.max_rpm;
      endcase
   endfunction

   task automatic decode_item(logic [qdr_pkg::MODE_W-1:0] mode, logic [1:0] cur);
      logic [qdr_pkg::HALF_W-1:0] half;
      enc_status_type             status;
      case (mode)
         qdr_pkg::MODE_SAMPLE: begin
            if (gray_fwd(prev_ab) == cur) begin
               edge_cnt = edge_cnt + 1'b1;
               dir_q    = qdr_pkg::DIR_FWD;
            end else if (gray_fwd(cur) == prev_ab) begin
               edge_cnt = edge_cnt - 1'b1;
               dir_q    = qdr_pkg::DIR_BACK;
            end else begin
               dir_q = qdr_pkg::DIR_STOP;
            end
            prev_ab = cur;
         end
         qdr_pkg::MODE_TICK: begin
            half      = edge_cnt[qdr_pkg::COUNT_BITS-1:1];
            rpm_q     = tick_speed(half);
            last_half = half;
         end
         qdr_pkg::MODE_LOAD: begin
            prev_ab   = cur;
            edge_cnt  = '0;
            last_half = '0;
            dir_q     = qdr_pkg::DIR_STOP;
            rpm_q     = '0;
         end
         default: ;  // unused mode leaves the state alone
      endcase
      status.direction  = dir_q;
      status.half_count = edge_cnt[qdr_pkg::COUNT_BITS-1:1];
      status.speed_rpm  = rpm_q;
      expected_status.push_back(status);
   endtask

   task automatic check_status();
      enc_status_type want;
      if (expected_status.size() == 0) begin
         $display("%0t: result transfer with nothing expected (dir %0d half %0d rpm %0d)",
                  $realtime, rsp_direction, rsp_half_count, rsp_speed_rpm);
         mismatch_count++;
         return;
      end
      want = expected_status.pop_front();
      if (rsp_direction !== want.direction) begin
         $display("%0t: direction expected %0d actual %0d",
                  $realtime, want.direction, rsp_direction);
         mismatch_count++;
      end
      if (rsp_half_count !== want.half_count) begin
         $display("%0t: half_count expected %0d actual %0d",
                  $realtime, want.half_count, rsp_half_count);
         mismatch_count++;
      end
      if (rsp_speed_rpm !== want.speed_rpm) begin
         $display("%0t: speed_rpm expected %0d actual %0d",
                  $realtime, want.speed_rpm, rsp_speed_rpm);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      qdr_pkg::reg_index_type idx;
      idx = qdr_pkg::reg_index_type'(csr_paddr[qdr_pkg::CSR_ADDR_W-1:2]);
      if (reset) begin
         cfg.count_modulus    = qdr_pkg::COUNT_MODULUS_RST;
         cfg.sample_period_ms = qdr_pkg::SAMPLE_PERIOD_RST;
         cfg.pulses_per_rev   = qdr_pkg::PULSES_RST;
         cfg.max_rpm          = qdr_pkg::MAX_RPM_RST;
         prev_ab   = '0;
         edge_cnt  = '0;
         last_half = '0;
         dir_q     = qdr_pkg::DIR_STOP;
         rpm_q     = '0;
         expected_status.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (idx)
                  qdr_pkg::REG_COUNT_MODULUS:
                     cfg.count_modulus    = csr_pwdata[qdr_pkg::CFG_W-1:0];
                  qdr_pkg::REG_SAMPLE_PERIOD:
                     cfg.sample_period_ms = csr_pwdata[qdr_pkg::CFG_W-1:0];
                  qdr_pkg::REG_PULSES:
                     cfg.pulses_per_rev   = csr_pwdata[qdr_pkg::CFG_W-1:0];
                  default:
                     cfg.max_rpm          = csr_pwdata[qdr_pkg::CFG_W-1:0];
               endcase
            end else if (csr_prdata !== qdr_pkg::CSR_DATA_W'(reg_value(idx))) begin
               $display("%0t: register %0d read expected %0d actual %0d",
                        $realtime, idx, reg_value(idx), csr_prdata);
               mismatch_count++;
            end
         end
         if (rsp_pop && !rsp_empty)
            check_status();
         if (req_push && !req_full)
            decode_item(req_mode, {req_phase_a, req_phase_b});
      end
      outstanding = expected_status.size();
   end

endmodule

FILE: dv/tb_quadrature_decoder_rpm.sv
// Top of the quadrature decoder testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_quadrature_decoder_rpm;

   localparam logic [qdr_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam int TICK_CYCLES    = 101;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_ITEMS    = 140;

   logic                           clock;
   logic                           reset       = 1'b1;
   logic                           req_push    = 1'b0;
   logic                           req_full;
   logic [qdr_pkg::MODE_W-1:0]     req_mode    = qdr_pkg::MODE_SAMPLE;
   logic                           req_phase_a = 1'b0;
   logic                           req_phase_b = 1'b0;
   logic                           rsp_empty;
   logic                           rsp_pop     = 1'b0;
   logic [qdr_pkg::DIR_W-1:0]      rsp_direction;
   logic [qdr_pkg::HALF_OUT_W-1:0] rsp_half_count;
   logic [qdr_pkg::RPM_W-1:0]      rsp_speed_rpm;
   logic                           csr_psel    = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite  = 1'b0;
   logic [qdr_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [qdr_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [qdr_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   int   mismatch_count;
   int   outstanding;
   int   stall_cycles;
   bit   hold_off_req;
   bit   run_fwd;
   logic [1:0] levels;   // {A,B} last sent to the decoder in a sample or load item

   quadrature_decoder_rpm dut (.*);

   qdr_decode_checker decode_check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_psel && csr_penable))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_quadrature_decoder_rpm: done, errors");
         $finish;
      end
   end

   // result side: stall style changes every so often, plus one long hold-off on request
   initial begin
      int style;
      int span;
      while (reset) @(negedge clock);
      forever begin
         style = $urandom_range(0, 3);
         span  = $urandom_range(20, 200);
         repeat (span) begin
            @(negedge clock);
            if (hold_off_req) begin
               rsp_pop <= 1'b0;
               repeat (HOLD_CYCLES) @(negedge clock);
               hold_off_req = 1'b0;
            end else begin
               case (style)
                  0:       rsp_pop <= 1'b1;
                  1:       rsp_pop <= 1'($urandom_range(0, 1));
                  2:       rsp_pop <= ($urandom_range(0, 3) == 0);
                  default: rsp_pop <= ($urandom_range(0, 7) != 0);
               endcase
            end
         end
      end
   end

   function automatic logic [1:0] gray_next(logic [1:0] ab);
      case (ab)
         2'b00:   return 2'b01;
         2'b01:   return 2'b11;
         2'b11:   return 2'b10;
         default: return 2'b00;
      endcase
   endfunction

   function automatic logic [1:0] gray_prev(logic [1:0] ab);
      case (ab)
         2'b01:   return 2'b00;
         2'b11:   return 2'b01;
         2'b10:   return 2'b11;
         default: return 2'b10;
      endcase
   endfunction

   task automatic send_item(logic [qdr_pkg::MODE_W-1:0] mode, logic [1:0] ab);
      @(negedge clock);
      req_push    <= 1'b1;
      req_mode    <= mode;
      req_phase_a <= ab[1];
      req_phase_b <= ab[0];
      do @(posedge clock); while (req_full);
      if (mode == qdr_pkg::MODE_SAMPLE || mode == qdr_pkg::MODE_LOAD)
         levels = ab;
   endtask

   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         req_push <= 1'b0;
      end
   endtask

   task automatic csr_write(qdr_pkg::reg_index_type idx, logic [qdr_pkg::CFG_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= qdr_pkg::CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= qdr_pkg::CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_read(qdr_pkg::reg_index_type idx);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= qdr_pkg::CSR_ADDR_W'({idx, 2'b00});
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic read_all_regs();
      csr_read(qdr_pkg::REG_COUNT_MODULUS);
      csr_read(qdr_pkg::REG_SAMPLE_PERIOD);
      csr_read(qdr_pkg::REG_PULSES);
      csr_read(qdr_pkg::REG_MAX_RPM);
   endtask

   task automatic apply_setting(logic [qdr_pkg::CFG_W-1:0] modulus,
                                logic [qdr_pkg::CFG_W-1:0] period,
                                logic [qdr_pkg::CFG_W-1:0] ppr,
                                logic [qdr_pkg::CFG_W-1:0] rpm_cap);
      csr_write(qdr_pkg::REG_COUNT_MODULUS, modulus);
      csr_write(qdr_pkg::REG_SAMPLE_PERIOD, period);
      csr_write(qdr_pkg::REG_PULSES, ppr);
      csr_write(qdr_pkg::REG_MAX_RPM, rpm_cap);
      read_all_regs();
   endtask

   // wait until every expected result has been transferred
   task automatic drain();
      idle_cycles(1);
      while (outstanding != 0) @(negedge clock);
   endtask

   // mostly clean quadrature walks, with ticks, reversals, glitches and loads mixed in
   task automatic send_random_item();
      int         pick;
      logic [1:0] ab;
      pick = $urandom_range(0, 99);
      ab   = 2'($urandom_range(0, 3));
      if (pick < 68)
         send_item(qdr_pkg::MODE_SAMPLE, run_fwd ? gray_next(levels) : gray_prev(levels));
      else if (pick < 80)
         send_item(qdr_pkg::MODE_TICK, ab);
      else if (pick < 85)
         send_item(qdr_pkg::MODE_SAMPLE, run_fwd ? gray_prev(levels) : gray_next(levels));
      else if (pick < 89)
         send_item(qdr_pkg::MODE_SAMPLE, levels);
      else if (pick < 93)
         send_item(qdr_pkg::MODE_SAMPLE, ~levels);
      else if (pick < 97)
         send_item(qdr_pkg::MODE_SAMPLE, ab);
      else if (pick < 99)
         send_item(qdr_pkg::MODE_LOAD, ab);
      else
         send_item(MODE_UNUSED, ab);
      if ($urandom_range(0, 39) == 0)
         run_fwd = ~run_fwd;
   endtask

   task automatic run_phase(int n, bit pressure);
      int sent;
      int burst;
      sent = 0;
      if (pressure)
         hold_off_req = 1'b1;
      while (sent < n) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && sent < n; k++) begin
            send_random_item();
            sent++;
         end
         if (!pressure && $urandom_range(0, 3) != 0)
            idle_cycles($urandom_range(1, 12));
      end
      drain();
   endtask

   task automatic directed_items();
      send_item(qdr_pkg::MODE_SAMPLE, 2'b00);     // no change
      repeat (4) send_item(qdr_pkg::MODE_SAMPLE, gray_next(levels));
      send_item(qdr_pkg::MODE_TICK, 2'b11);
      repeat (4) send_item(qdr_pkg::MODE_SAMPLE, gray_prev(levels));
      send_item(qdr_pkg::MODE_TICK, 2'b00);       // negative difference wraps
      send_item(qdr_pkg::MODE_SAMPLE, 2'b11);     // double steps
      send_item(qdr_pkg::MODE_SAMPLE, 2'b00);
      send_item(qdr_pkg::MODE_SAMPLE, 2'b01);
      send_item(qdr_pkg::MODE_SAMPLE, 2'b10);
      send_item(qdr_pkg::MODE_SAMPLE, 2'b01);
      send_item(qdr_pkg::MODE_SAMPLE, 2'b01);
      send_item(qdr_pkg::MODE_SAMPLE, 2'b11);
      send_item(qdr_pkg::MODE_SAMPLE, 2'b11);
      send_item(qdr_pkg::MODE_SAMPLE, 2'b10);
      send_item(qdr_pkg::MODE_SAMPLE, 2'b10);
      send_item(qdr_pkg::MODE_LOAD, 2'b11);
      send_item(MODE_UNUSED, 2'b10);
      send_item(qdr_pkg::MODE_SAMPLE, 2'b01);     // counter wraps below zero
      send_item(qdr_pkg::MODE_TICK, 2'b01);
      send_item(MODE_UNUSED, 2'b01);
      send_item(qdr_pkg::MODE_TICK, 2'b10);
      drain();
   endtask

   initial begin
      levels  = 2'b00;
      run_fwd = 1'b1;
      hold_off_req = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      read_all_regs();
      directed_items();

      // extremes and zero-register cases first, then random settings
      apply_setting(16'd32768, 16'd65535, 16'd1, 16'd65535);
      run_phase(PHASE_ITEMS, 1'b0);
      apply_setting(16'd1, 16'd1, 16'd65535, 16'd0);
      run_phase(PHASE_ITEMS, 1'b0);
      apply_setting(16'd0, 16'd0, 16'd7, 16'd1234);
      run_phase(PHASE_ITEMS / 2, 1'b0);
      apply_setting(16'd100, 16'd250, 16'd0, 16'd40000);
      run_phase(PHASE_ITEMS / 2, 1'b0);
      apply_setting(16'd32768, 16'd1, 16'd1, 16'd65535);
      run_phase(PHASE_ITEMS / 2, 1'b0);
      repeat (3) begin
         apply_setting(qdr_pkg::CFG_W'($urandom_range(1, 32768)),
                       qdr_pkg::CFG_W'($urandom_range(1, 2000)),
                       qdr_pkg::CFG_W'($urandom_range(1, 500)),
                       qdr_pkg::CFG_W'($urandom_range(0, 65535)));
         run_phase(PHASE_ITEMS, 1'b0);
      end
      apply_setting(qdr_pkg::COUNT_MODULUS_RST, qdr_pkg::SAMPLE_PERIOD_RST,
                    qdr_pkg::PULSES_RST, qdr_pkg::MAX_RPM_RST);
      run_phase(PHASE_ITEMS, 1'b1);
      apply_setting(qdr_pkg::CFG_W'($urandom_range(1, 32768)),
                    qdr_pkg::CFG_W'($urandom_range(1, 65535)),
                    qdr_pkg::CFG_W'($urandom_range(1, 65535)),
                    qdr_pkg::CFG_W'($urandom_range(0, 65535)));
      run_phase(PHASE_ITEMS, 1'b0);

      repeat (TICK_CYCLES + 20) @(negedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("tb_quadrature_decoder_rpm: done, clean");
      else
         $display("tb_quadrature_decoder_rpm: done, errors");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/qdr_pkg.sv
hdl/qdr_front.sv
hdl/qdr_cmd_fifo.sv
hdl/qdr_div.sv
hdl/qdr_back.sv
hdl/quadrature_decoder_rpm.sv
dv/qdr_decode_checker.sv
dv/tb_quadrature_decoder_rpm.sv
